[rtl/core/stb_pkg.sv]
// Package for the software timer bank: sizes, command and state codes,
// and the command record that the front end hands to the back end.
// No dependencies.
package stb_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int CH_W        = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int REPORTABLE  = 8;
  localparam int DELAY_W     = 16;
  localparam int KIND_W      = 3;
  localparam int INDEX_W     = 3;
  localparam int MODE_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE_SHOT = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK      = 3'd0,
    KIND_ADD       = 3'd1,
    KIND_PAUSE     = 3'd2,
    KIND_STOP      = 3'd3,
    KIND_CLEAR     = 3'd4,
    KIND_DELAY     = 3'd5,
    KIND_CLEAR_ALL = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_PAUSE,
    OP_STOP,
    OP_CLEAR,
    OP_DELAY,
    OP_CLEAR_ALL
  } op_e;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_WALK,
    BACK_FLUSH
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic [CH_W-1:0]    chan;
    logic [DELAY_W-1:0] delay;
    logic [MODE_W-1:0]  mode;
    logic               callback;
  } cmd_t;

endpackage

[rtl/core/stb_if.sv]
// Channel interfaces of the software timer bank: input items and fired
// results, each with a valid/ready handshake. Depends on stb_pkg.
interface stb_in_if
  import stb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [INDEX_W-1:0] timer_index;
  logic [DELAY_W-1:0] delay_value;
  logic [MODE_W-1:0]  timer_mode;
  logic               has_callback;

  modport source (
    output valid, kind, timer_index, delay_value, timer_mode, has_callback,
    input  ready
  );
  modport sink (
    input  valid, kind, timer_index, delay_value, timer_mode, has_callback,
    output ready
  );
endinterface

interface stb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] fired_index;
  logic       last_fired;

  modport source (
    output valid, fired_index, last_fired,
    input  ready
  );
  modport sink (
    input  valid, fired_index, last_fired,
    output ready
  );
endinterface

[rtl/core/software_timer_bank.sv]
// Top level of the software timer bank: front end, command queue and
// back end. Depends on stb_pkg, stb_if, stb_front, stb_queue, stb_back.
//
// A bank of NUM_TIMERS timer channels. The back end executes a command (add,
// pause, stop, clear counter, set delay, clear all counters) as it dequeues
// it. A tick is dequeued, then the back end walks the channel registers,
// holding the walk while an expiry waits on a stalled result channel, and
// then reports the final expiry. The front end keeps accepting items into a
// two-entry queue while the back end is busy, until the queue is full. Each
// expiry with a callback yields one result; the last result of a tick has
// last_fired set, and a tick with no such expiry yields nothing.
module software_timer_bank
  import stb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  stb_in_if.sink     in_i,
  stb_out_if.source  out_o
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  stb_front u_front (
    .valid_i        (in_i.valid),
    .ready_o        (in_i.ready),
    .kind_i         (in_i.kind),
    .timer_index_i  (in_i.timer_index),
    .delay_value_i  (in_i.delay_value),
    .timer_mode_i   (in_i.timer_mode),
    .has_callback_i (in_i.has_callback),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  stb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  stb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .fired_index_o (out_o.fired_index),
    .last_fired_o  (out_o.last_fired)
  );

endmodule

[rtl/core/stb_front.sv]
// Front end of the software timer bank: accepts input items, decodes them
// and drops those that have no effect. Depends on stb_pkg.
module stb_front
  import stb_pkg::*;
(
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [INDEX_W-1:0] timer_index_i,
  input  logic [DELAY_W-1:0] delay_value_i,
  input  logic [MODE_W-1:0]  timer_mode_i,
  input  logic               has_callback_i,
  input  logic               q_full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic in_range;
  logic keep;

  assign ready_o  = !q_full_i;
  assign in_range = 32'(timer_index_i) < NUM_TIMERS;

  always_comb begin
    cmd_o.op       = OP_TICK;
    cmd_o.chan     = CH_W'(timer_index_i);
    cmd_o.delay    = delay_value_i;
    cmd_o.mode     = timer_mode_i;
    cmd_o.callback = has_callback_i;
    keep           = 1'b0;
    unique case (kind_i)
      KIND_TICK: begin
        cmd_o.op = OP_TICK;
        keep     = 1'b1;
      end
      KIND_CLEAR_ALL: begin
        cmd_o.op = OP_CLEAR_ALL;
        keep     = 1'b1;
      end
      KIND_ADD: begin
        cmd_o.op = OP_ADD;
        keep     = in_range;
      end
      KIND_PAUSE: begin
        cmd_o.op = OP_PAUSE;
        keep     = in_range;
      end
      KIND_STOP: begin
        cmd_o.op = OP_STOP;
        keep     = in_range;
      end
      KIND_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        keep     = in_range;
      end
      KIND_DELAY: begin
        cmd_o.op = OP_DELAY;
        keep     = in_range;
      end
      default: begin
        // The unused kind code is accepted and discarded.
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = valid_i && ready_o && keep;

endmodule

[rtl/core/stb_queue.sv]
// Short command queue between the front end and the back end of the
// software timer bank. Depends on stb_pkg.
module stb_queue
  import stb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]  count_q, count_d;
  logic                do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == Q_CNT_W'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[rtl/core/stb_back.sv]
// Back end of the software timer bank: holds channel state, runs commands
// and walks the channels on a tick, one per cycle unless stalled, reporting
// expiries through an output register. Depends on stb_pkg.
module stb_back
  import stb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       q_empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] fired_index_o,
  output logic       last_fired_o
);

  back_state_e        state_q, state_d;
  logic               en_q    [NUM_TIMERS];
  logic [DELAY_W-1:0] delay_q [NUM_TIMERS];
  logic [DELAY_W-1:0] count_q [NUM_TIMERS];
  logic [MODE_W-1:0]  mode_q  [NUM_TIMERS];
  logic               cb_q    [NUM_TIMERS];

  logic [CH_W-1:0]    walk_q;
  logic               pend_valid_q;
  logic [CH_W-1:0]    pend_idx_q;
  logic               out_valid_q;
  logic [2:0]         out_idx_q;
  logic               out_last_q;

  logic [DELAY_W-1:0] inc;
  logic               hit;
  logic               report;
  logic               push_ok;
  logic               walk_stall;
  logic               walk_last;
  logic               push;
  logic               push_last;

  // Evaluation of the channel the walk is on.
  assign inc       = count_q[walk_q] + 1'b1;
  assign hit       = en_q[walk_q] && (inc == delay_q[walk_q]) &&
                     (mode_q[walk_q] != MODE_NONE);
  assign report    = hit && cb_q[walk_q] && (32'(walk_q) < REPORTABLE);
  assign push_ok   = !out_valid_q || out_ready_i;
  assign walk_last = (32'(walk_q) == NUM_TIMERS - 1);
  // A new report can only be taken once the one held back has gone out.
  assign walk_stall = (state_q == BACK_WALK) && report && pend_valid_q && !push_ok;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BACK_IDLE: begin
        if (!q_empty_i && cmd_i.op == OP_TICK) begin
          state_d = BACK_WALK;
        end
      end
      BACK_WALK: begin
        if (!walk_stall && walk_last) begin
          state_d = BACK_FLUSH;
        end
      end
      BACK_FLUSH: begin
        if (!pend_valid_q || push_ok) begin
          state_d = BACK_IDLE;
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state_q)
      BACK_IDLE: begin
        pop_o = !q_empty_i;
      end
      BACK_WALK: begin
        push = report && pend_valid_q && push_ok;
      end
      BACK_FLUSH: begin
        push      = pend_valid_q && push_ok;
        push_last = 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BACK_IDLE;
      walk_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_last_q   <= 1'b0;
      for (int c = 0; c < NUM_TIMERS; c++) begin
        en_q[c]    <= 1'b0;
        delay_q[c] <= '0;
        count_q[c] <= '0;
        mode_q[c]  <= MODE_NONE;
        cb_q[c]    <= 1'b0;
      end
    end else begin
      state_q <= state_d;

      if (push) begin
        out_valid_q <= 1'b1;
        out_idx_q   <= 3'(pend_idx_q);
        out_last_q  <= push_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (state_q == BACK_IDLE && pop_o) begin
        walk_q       <= '0;
        pend_valid_q <= 1'b0;
        case (cmd_i.op)
          OP_ADD: begin
            delay_q[cmd_i.chan] <= cmd_i.delay;
            count_q[cmd_i.chan] <= '0;
            mode_q[cmd_i.chan]  <= cmd_i.mode;
            cb_q[cmd_i.chan]    <= cmd_i.callback;
            en_q[cmd_i.chan]    <= 1'b1;
          end
          OP_PAUSE: begin
            en_q[cmd_i.chan] <= 1'b0;
          end
          OP_STOP: begin
            en_q[cmd_i.chan]    <= 1'b0;
            delay_q[cmd_i.chan] <= '0;
            count_q[cmd_i.chan] <= '0;
            mode_q[cmd_i.chan]  <= MODE_NONE;
            cb_q[cmd_i.chan]    <= 1'b0;
          end
          OP_CLEAR: begin
            count_q[cmd_i.chan] <= '0;
          end
          OP_DELAY: begin
            count_q[cmd_i.chan] <= '0;
            delay_q[cmd_i.chan] <= cmd_i.delay;
          end
          OP_CLEAR_ALL: begin
            for (int c = 0; c < NUM_TIMERS; c++) begin
              count_q[c] <= '0;
            end
          end
          default: begin
            walk_q <= '0;
          end
        endcase
      end

      if (state_q == BACK_WALK && !walk_stall) begin
        walk_q <= walk_q + 1'b1;
        if (en_q[walk_q]) begin
          if (hit) begin
            count_q[walk_q] <= '0;
            if (mode_q[walk_q] == MODE_ONE_SHOT) begin
              en_q[walk_q]    <= 1'b0;
              delay_q[walk_q] <= '0;
              mode_q[walk_q]  <= MODE_NONE;
              cb_q[walk_q]    <= 1'b0;
            end
          end else begin
            count_q[walk_q] <= inc;
          end
        end
        if (report) begin
          pend_valid_q <= 1'b1;
          pend_idx_q   <= walk_q;
        end
      end

      if (state_q == BACK_FLUSH && push) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fired_index_o = out_idx_q;
  assign last_fired_o  = out_last_q;

endmodule
